// ===== hw/rtl/ple_pkg.sv =====
// ple_pkg: shared types, codes and field widths of the positional list engine
// no dependencies; used by the channel interfaces, the entry store and the top level
`default_nettype none

package ple_pkg;

   // fixed field widths of the request and response items
   localparam int FuncWidth     = 3;
   localparam int PositionWidth = 5;
   localparam int ValueWidth    = 32;
   localparam int StatusWidth   = 2;
   localparam int CountWidth    = 5;

   // default list depth
   localparam int DefaultCapacity = 16;

   typedef enum logic [FuncWidth-1:0] {
      FN_INS_FRONT = 3'd0,
      FN_INS_BACK  = 3'd1,
      FN_INS_POS   = 3'd2,
      FN_DEL_FRONT = 3'd3,
      FN_DEL_BACK  = 3'd4,
      FN_DEL_POS   = 3'd5
   } func_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ple_req_if.sv =====
// ple_req_if: valid/ready request channel of the positional list engine
// depends on ple_pkg for the field widths
`default_nettype none

interface ple_req_if
   import ple_pkg::*;
();
   logic                           valid;
   logic                           ready;
   logic        [FuncWidth-1:0]    func;
   logic        [PositionWidth-1:0] position;
   logic signed [ValueWidth-1:0]   value;

   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ple_rsp_if.sv =====
// ple_rsp_if: valid/ready response channel of the positional list engine
// depends on ple_pkg for the field widths
`default_nettype none

interface ple_rsp_if
   import ple_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [ValueWidth-1:0]  removed_value;
   logic        [StatusWidth-1:0] status;
   logic        [CountWidth-1:0]  entry_count;

   modport source (output valid, removed_value, status, entry_count, input ready);
   modport sink   (input valid, removed_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ple_store.sv =====
// ple_store: entry memory of the list, one write and one registered read per cycle
// depends on ple_pkg for the word width
`default_nettype none

module ple_store
   import ple_pkg::*;
#(
   parameter int Capacity = DefaultCapacity,
   localparam int IdxWidth = (Capacity > 1) ? $clog2(Capacity) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IdxWidth-1:0]   wr_addr,
   input  wire logic [ValueWidth-1:0] wr_data,
   input  wire logic [IdxWidth-1:0]   rd_addr,
   output      logic [ValueWidth-1:0] rd_data
);

   logic [ValueWidth-1:0] mem [Capacity];
   logic [ValueWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_engine.sv =====
// positional_list_engine: ordered list of signed words with positional insert and delete
// depends on ple_pkg, ple_req_if, ple_rsp_if and ple_store
//
// usage
//   req_if carries one request item: func, position (1-based) and value.
//   rsp_if returns exactly one item per request: removed_value, status and
//   entry_count after the request. both are valid/ready channels.
// timing
//   the list lives in a single-port-write memory with a registered read; a
//   small sequencer moves each entry with a read state, then a write state,
//   using one shared +/-1 index unit and index compares against the walk end.
//   a rejected or unused request goes straight to the response state.
//   req_if.ready is high only while the engine is idle, so one item is in
//   flight at a time.
// reset
//   synchronous, active high: the list becomes empty, no response pending.
//   memory contents are not cleared; only entries below the count are read.
// back pressure
//   the response is held in registers until rsp_if.ready; no new request is
//   taken until the held response has been delivered.
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
) (
   input wire logic  clock,
   input wire logic  reset,
   ple_req_if.sink   req_if,
   ple_rsp_if.source rsp_if
);

   // index into the store, count that can hold CAPACITY itself
   localparam int IdxWidth = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntWidth = $clog2(CAPACITY + 1);
   // compare width wide enough for position and count + 1
   localparam int CmpWidth = ((CntWidth > PositionWidth) ? CntWidth : PositionWidth) + 1;

   // sequencer states, one-hot
   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SHIFT_RD = 8'b0000_0010,  // read the neighbor of the current slot
      S_SHIFT_WR = 8'b0000_0100,  // write it into the current slot
      S_PUT      = 8'b0000_1000,  // drop the new word into the opened gap
      S_GRAB_RD  = 8'b0001_0000,  // read the word being deleted
      S_GRAB     = 8'b0010_0000,  // capture it
      S_DROP     = 8'b0100_0000,  // shrink the count
      S_RESP     = 8'b1000_0000   // response waiting on rsp_if
   } state_type;

   state_type state_ff, state_in;

   logic                  is_ins_ff, is_ins_in;   // direction of the shift walk
   logic [IdxWidth-1:0]   ptr_ff, ptr_in;         // slot being written
   logic [IdxWidth-1:0]   limit_ff, limit_in;     // walk end: gap index or last index
   logic [ValueWidth-1:0] word_ff, word_in;       // word to insert
   logic [CntWidth-1:0]   count_ff, count_in;
   logic [ValueWidth-1:0] removed_ff, removed_in;
   status_type            status_ff, status_in;

   // store port
   logic                  wr_en;
   logic [IdxWidth-1:0]   wr_addr;
   logic [ValueWidth-1:0] wr_data;
   logic [IdxWidth-1:0]   rd_addr;
   logic [ValueWidth-1:0] rd_data;

   // shared index unit
   logic [IdxWidth-1:0]   ptr_step;
   logic                  walk_more;

   // request decode
   logic                  req_take;
   logic [CmpWidth-1:0]   pos_ext;
   logic [CmpWidth-1:0]   cnt_ext;
   logic [CmpWidth-1:0]   pos_m1;
   logic [IdxWidth-1:0]   pos_idx;
   logic [IdxWidth-1:0]   cnt_idx;
   logic [IdxWidth-1:0]   last_idx;
   logic                  list_full;
   logic                  list_empty;
   logic                  ins_bad;
   logic                  del_bad;
   logic [IdxWidth-1:0]   ins_idx;
   logic [IdxWidth-1:0]   del_idx;

   ple_store #(
      .Capacity (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_take = req_if.valid && (state_ff == S_IDLE);

   assign pos_ext    = CmpWidth'(req_if.position);
   assign cnt_ext    = CmpWidth'(count_ff);
   assign pos_m1     = pos_ext - CmpWidth'(1);
   assign pos_idx    = pos_m1[IdxWidth-1:0];
   assign cnt_idx    = IdxWidth'(count_ff);
   assign last_idx   = IdxWidth'(count_ff - CntWidth'(1));
   assign list_full  = (count_ff == CntWidth'(CAPACITY));
   assign list_empty = (count_ff == '0);

   // position zero and positions past the end are rejected
   assign ins_bad = (pos_ext == '0) || (pos_ext > (cnt_ext + CmpWidth'(1)));
   assign del_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

   always_comb begin
      case (req_if.func)
         FN_INS_FRONT: ins_idx = '0;
         FN_INS_BACK:  ins_idx = cnt_idx;
         default:      ins_idx = pos_idx;
      endcase
      case (req_if.func)
         FN_DEL_FRONT: del_idx = '0;
         FN_DEL_BACK:  del_idx = last_idx;
         default:      del_idx = pos_idx;
      endcase
   end

   // one +/-1 step toward the walk end
   assign ptr_step  = is_ins_ff ? (ptr_ff - IdxWidth'(1)) : (ptr_ff + IdxWidth'(1));
   assign walk_more = (ptr_step != limit_ff);

   // store addressing
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data;
      rd_addr = ptr_ff;
      case (state_ff)
         S_SHIFT_RD: rd_addr = ptr_step;
         S_SHIFT_WR: wr_en   = 1'b1;
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = limit_ff;
            wr_data = word_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      is_ins_in  = is_ins_ff;
      ptr_in     = ptr_ff;
      limit_in   = limit_ff;
      word_in    = word_ff;
      count_in   = count_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               word_in    = req_if.value;
               removed_in = '0;
               status_in  = ST_OK;
               state_in   = S_RESP;
               case (req_if.func)
                  FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
                     if (list_full) begin
                        status_in = ST_FULL;
                     end else if ((req_if.func == FN_INS_POS) && ins_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        // walk from the end down to the gap
                        is_ins_in = 1'b1;
                        limit_in  = ins_idx;
                        ptr_in    = cnt_idx;
                        state_in  = (cnt_idx == ins_idx) ? S_PUT : S_SHIFT_RD;
                     end
                  end
                  FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
                     if (list_empty) begin
                        status_in = ST_EMPTY;
                     end else if ((req_if.func == FN_DEL_POS) && del_bad) begin
                        status_in = ST_BADPOS;
                     end else begin
                        // walk from the hole up to the last entry
                        is_ins_in = 1'b0;
                        limit_in  = last_idx;
                        ptr_in    = del_idx;
                        state_in  = S_GRAB_RD;
                     end
                  end
                  default: ;  // unused codes leave the list alone
               endcase
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            ptr_in = ptr_step;
            if (walk_more) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = is_ins_ff ? S_PUT : S_DROP;
            end
         end
         S_PUT: begin
            count_in = count_ff + CntWidth'(1);
            state_in = S_RESP;
         end
         S_GRAB_RD: state_in = S_GRAB;
         S_GRAB: begin
            removed_in = rd_data;
            state_in   = (ptr_ff != limit_ff) ? S_SHIFT_RD : S_DROP;
         end
         S_DROP: begin
            count_in = count_ff - CntWidth'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      is_ins_ff  <= is_ins_in;
      ptr_ff     <= ptr_in;
      limit_ff   <= limit_in;
      word_ff    <= word_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   // channel outputs
   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = (state_ff == S_RESP);
   assign rsp_if.removed_value = removed_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.entry_count   = CountWidth'(count_ff);

endmodule

`default_nettype wire
